@@ rtl/core/zcev_pkg.sv @@
// Shared types, codes and defaults for the zero-crossing event unit.
`default_nettype none
package zcev_pkg;

    localparam int SLOT_COUNT_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // widths of the fixed result fields
    localparam int SLOT_NUM_W = 5;
    localparam int NOTIFY_W   = 16;
    localparam int FREQ_W     = 16;
    // slot index plus one never exceeds 32, so six bits always hold it
    localparam int SLOT_WIDE_W = 6;
    localparam int PAD_W       = 32;

    typedef enum logic [1:0] {
        KIND_SAMPLE      = 2'd0,
        KIND_TICK        = 2'd1,
        KIND_SUBSCRIBE   = 2'd2,
        KIND_UNSUBSCRIBE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RES_OK      = 2'd0,
        RES_INVALID = 2'd1,
        RES_BUSY    = 2'd2
    } t_result;

    // edge codes line up with the subscribe mask bits
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_FALL = 2'd2;

    // control broadcast to every slot cell
    typedef struct packed {
        logic       subscribe;
        logic [1:0] mask;
        logic [1:0] edge_sel;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ rtl/core/zcev_slot_cell.sv @@
// One subscription slot: holds its edge mask and passes the free-slot claim on.
`default_nettype none
module zcev_slot_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire zcev_pkg::t_cell_ctl  i_ctl,
    input  wire logic                 i_release,
    input  wire logic                 i_claim,
    output logic                      o_claim,
    output logic                      o_taken,
    output logic                      o_notify
);

    logic [1:0] r_mask;
    logic [1:0] n_mask;
    logic       free;

    assign free     = (r_mask == 2'b00);
    assign o_taken  = i_claim && free;
    assign o_claim  = i_claim && !free;
    assign o_notify = |(r_mask & i_ctl.edge_sel);

    always_comb begin
        n_mask = r_mask;
        if (i_release) begin
            n_mask = 2'b00;
        end else if (i_ctl.subscribe && o_taken) begin
            n_mask = i_ctl.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 2'b00;
        end else begin
            r_mask <= n_mask;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/zcev_rate_counter.sv @@
// Level tracking, edge detection and a rising-edge count between ticks.
`default_nettype none
module zcev_rate_counter #(
    parameter int COUNT_WIDTH = zcev_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_sample,
    input  wire logic                   i_tick,
    input  wire logic                   i_level,
    output logic [1:0]                  o_edge_sel,
    output logic [COUNT_WIDTH-1:0]      o_freq_next,
    output logic                        o_pending_next
);

    logic                   r_prev_level;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] r_freq;
    logic                   r_pending;

    logic                   n_prev_level;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] base;
    logic                   rise;
    logic                   fall;

    assign rise = i_sample && i_level && !r_prev_level;
    assign fall = i_sample && !i_level && r_prev_level;

    always_comb begin
        o_edge_sel = zcev_pkg::EDGE_NONE;
        if (rise) begin
            o_edge_sel = zcev_pkg::EDGE_RISE;
        end else if (fall) begin
            o_edge_sel = zcev_pkg::EDGE_FALL;
        end
    end

    // first rise after a tick restarts the count; count saturates
    assign base = r_pending ? '0 : r_count;

    always_comb begin
        n_prev_level   = r_prev_level;
        n_count        = r_count;
        o_freq_next    = r_freq;
        o_pending_next = r_pending;
        if (i_sample) begin
            n_prev_level = i_level;
        end
        if (i_tick) begin
            o_pending_next = 1'b1;
        end
        if (rise) begin
            if (r_pending) begin
                o_freq_next    = r_count;
                o_pending_next = 1'b0;
            end
            n_count = (base != '1) ? base + COUNT_WIDTH'(1) : base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_count      <= '0;
            r_freq       <= '0;
            r_pending    <= 1'b0;
        end else begin
            r_prev_level <= n_prev_level;
            r_count      <= n_count;
            r_freq       <= o_freq_next;
            r_pending    <= o_pending_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/zero_crossing_event_unit.sv @@
// Top level of the zero-crossing event unit: slot cell chain, counter, result register.
`default_nettype none
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_kind, i_level, i_edge_mask,
//          |           |                          | i_slot_number
//  out     | output    | o_out_valid / i_out_ready| o_result_code, o_granted_slot,
//          |           |                          | o_edge_kind, o_notify_slots, o_frequency,
//          |           |                          | o_frequency_fresh
//
//  One item per cycle while the output is not stalled. An accepted item is resolved in the
//  cycle it is taken and its result lands in the output register at that edge.
//  The critical path is the free-slot claim rippling through the SLOT_COUNT slot cells.
//  Input ready stays high while the output register is empty or being drained, so a
//  stalled output holds exactly one result and blocks new items only then.
//  Synchronous active-low reset frees every slot, clears level, counter and frequency.
//
module zero_crossing_event_unit #(
    parameter int SLOT_COUNT  = zcev_pkg::SLOT_COUNT_DEF,
    parameter int COUNT_WIDTH = zcev_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic        i_level,
    input  wire logic [1:0]  i_edge_mask,
    input  wire logic [4:0]  i_slot_number,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_result_code,
    output logic [4:0]       o_granted_slot,
    output logic [1:0]       o_edge_kind,
    output logic [15:0]      o_notify_slots,
    output logic [15:0]      o_frequency,
    output logic             o_frequency_fresh
);

    localparam int SW = zcev_pkg::SLOT_WIDE_W;
    localparam int PW = zcev_pkg::PAD_W;

    // ---------------------------------------------------------------- decode
    zcev_pkg::t_kind     kind;
    zcev_pkg::t_cell_ctl ctl;
    logic                accept;
    logic                do_sample;
    logic                do_tick;
    logic                do_sub;
    logic                unsub_ok;
    logic [SW-1:0]       slot_wide;

    assign kind      = zcev_pkg::t_kind'(i_kind);
    assign accept    = i_in_valid && o_in_ready;
    assign do_sample = accept && (kind == zcev_pkg::KIND_SAMPLE);
    assign do_tick   = accept && (kind == zcev_pkg::KIND_TICK);
    assign do_sub    = accept && (kind == zcev_pkg::KIND_SUBSCRIBE) && (i_edge_mask != 2'b00);
    assign slot_wide = {1'b0, i_slot_number};
    // one-based slot, valid range 1..SLOT_COUNT
    assign unsub_ok  = (slot_wide != '0) && (slot_wide <= SW'(SLOT_COUNT));

    // ---------------------------------------------------------------- counter
    logic [1:0]             edge_sel;
    logic [COUNT_WIDTH-1:0] freq_next;
    logic                   pending_next;

    zcev_rate_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (do_sample),
        .i_tick         (do_tick),
        .i_level        (i_level),
        .o_edge_sel     (edge_sel),
        .o_freq_next    (freq_next),
        .o_pending_next (pending_next)
    );

    // ---------------------------------------------------------------- slot chain
    // claim[0] enters at slot 1; it passes each occupied cell and stops at the
    // first free one. Still open at the far end means the table is full.
    logic [SLOT_COUNT:0]   claim;
    logic [SLOT_COUNT-1:0] taken;
    logic [SLOT_COUNT-1:0] notify_vec;

    assign claim[0]     = 1'b1;
    assign ctl.subscribe = do_sub;
    assign ctl.mask      = i_edge_mask;
    assign ctl.edge_sel  = edge_sel;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        logic rel;
        assign rel = accept && (kind == zcev_pkg::KIND_UNSUBSCRIBE) && unsub_ok
                     && (slot_wide == SW'(g + 1));

        zcev_slot_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_release (rel),
            .i_claim   (claim[g]),
            .o_claim   (claim[g+1]),
            .o_taken   (taken[g]),
            .o_notify  (notify_vec[g])
        );
    end

    // taken is one-hot, so OR the slot numbers together
    logic [SW-1:0] granted_wide;
    always_comb begin
        granted_wide = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (taken[i]) begin
                granted_wide = granted_wide | SW'(i + 1);
            end
        end
    end

    // ---------------------------------------------------------------- result
    zcev_pkg::t_result res_code;
    logic [4:0]        res_granted;
    logic [PW-1:0]     notify_pad;
    logic [PW-1:0]     freq_pad;

    always_comb begin
        res_code    = zcev_pkg::RES_OK;
        res_granted = '0;
        case (kind)
            zcev_pkg::KIND_SUBSCRIBE: begin
                if (i_edge_mask == 2'b00) begin
                    res_code = zcev_pkg::RES_INVALID;
                end else if (claim[SLOT_COUNT]) begin
                    res_code = zcev_pkg::RES_BUSY;
                end else begin
                    res_granted = granted_wide[4:0];
                end
            end
            zcev_pkg::KIND_UNSUBSCRIBE: begin
                if (!unsub_ok) begin
                    res_code = zcev_pkg::RES_INVALID;
                end
            end
            default: begin
                res_code = zcev_pkg::RES_OK;
            end
        endcase
    end

    // edge_sel is none for anything but a changing sample, so notify follows
    assign notify_pad = PW'(notify_vec);
    assign freq_pad   = PW'(freq_next);

    // ---------------------------------------------------------------- output register
    logic              r_out_valid;
    zcev_pkg::t_result r_result_code;
    logic [4:0]        r_granted_slot;
    logic [1:0]        r_edge_kind;
    logic [15:0]       r_notify_slots;
    logic [15:0]       r_frequency;
    logic              r_frequency_fresh;

    assign o_in_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result_code     <= res_code;
            r_granted_slot    <= res_granted;
            r_edge_kind       <= edge_sel;
            r_notify_slots    <= notify_pad[15:0];
            r_frequency       <= freq_pad[15:0];
            r_frequency_fresh <= !pending_next;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_code     = r_result_code;
    assign o_granted_slot    = r_granted_slot;
    assign o_edge_kind       = r_edge_kind;
    assign o_notify_slots    = r_notify_slots;
    assign o_frequency       = r_frequency;
    assign o_frequency_fresh = r_frequency_fresh;

`ifndef SYNTHESIS
    // at most one cell takes a subscribe
    a_taken_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(taken))
        else $error("more than one slot claimed");

    // a grant is only ever an ok subscribe without an edge
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_granted_slot != 5'd0) |->
            (o_result_code == zcev_pkg::RES_OK) && (o_edge_kind == zcev_pkg::EDGE_NONE))
        else $error("grant with bad code or edge");

    // a rising edge always leaves the frequency fresh
    a_rise_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_edge_kind == zcev_pkg::EDGE_RISE) |-> o_frequency_fresh)
        else $error("rising edge left frequency stale");

    // an accepted item always produces a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted item produced no result");
`endif

endmodule
`default_nettype wire
